@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define SSD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define SSD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked through reset.
`define SSD_ASSERT_NEXT_ALWAYS(lbl, clk_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ssd_pkg.sv @@
// Shared constants, types and helpers of the sound/silence detector.
// No dependencies; compiled first.
package ssd_pkg;

  localparam int SSD_TIME_BITS  = 32;
  localparam int SSD_LEVEL_BITS = 16;
  localparam int POWER_BITS     = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int QUEUE_DEPTH    = 2;

  // register reset values
  localparam int DEF_THRESHOLD    = 410;
  localparam int DEF_SOUND_STEP   = 100;
  localparam int DEF_SILENCE_STEP = -100;
  localparam int DEF_INT_MIN      = 0;
  localparam int DEF_INT_MAX      = 1000;
  localparam int DEF_SOUND_ON     = 800;
  localparam int DEF_SILENCE_ON   = 200;
  localparam int DEF_LASTING_MS   = 120000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESHOLD    = 3'd0,
    REG_SOUND_STEP   = 3'd1,
    REG_SILENCE_STEP = 3'd2,
    REG_INT_MIN      = 3'd3,
    REG_INT_MAX      = 3'd4,
    REG_SOUND_ON     = 3'd5,
    REG_SILENCE_ON   = 3'd6,
    REG_LASTING_MS   = 3'd7
  } cfg_reg_t;

  // detector mode, one-hot inside the block
  typedef enum logic [2:0] {
    MODE_SILENCE = 3'b001,
    MODE_SOUND   = 3'b010,
    MODE_LASTING = 3'b100
  } mode_t;

  // codes shown on sound_state
  localparam logic [1:0] STATE_SILENCE = 2'd0;
  localparam logic [1:0] STATE_SOUND   = 2'd1;
  localparam logic [1:0] STATE_LASTING = 2'd2;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] code;
    unique case (m)
      MODE_SILENCE: code = STATE_SILENCE;
      MODE_SOUND:   code = STATE_SOUND;
      MODE_LASTING: code = STATE_LASTING;
      default:      code = STATE_SILENCE;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/core/ssd_in_if.sv @@
// Sample channel: power and timestamp with valid/ready.
// Depends on ssd_pkg.
interface ssd_in_if #(
  parameter int TIME_BITS = ssd_pkg::SSD_TIME_BITS
);
  logic                            valid;
  logic                            ready;
  logic [ssd_pkg::POWER_BITS-1:0]  power;
  logic [TIME_BITS-1:0]            timestamp_ms;

  modport source (output valid, power, timestamp_ms, input ready);
  modport sink   (input valid, power, timestamp_ms, output ready);
endinterface

@@ rtl/core/ssd_out_if.sv @@
// Result channel: detector state, change flag and integrator level.
// Depends on ssd_pkg.
interface ssd_out_if #(
  parameter int LEVEL_BITS = ssd_pkg::SSD_LEVEL_BITS
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   sound_state;
  logic                         state_changed;
  logic signed [LEVEL_BITS-1:0] integrator_level;

  modport source (output valid, sound_state, state_changed, integrator_level, input ready);
  modport sink   (input valid, sound_state, state_changed, integrator_level, output ready);
endinterface

@@ rtl/core/ssd_cfg_if.sv @@
// Register write channel: index and data with valid/ready.
// Depends on ssd_pkg. DATA_BITS must cover the widest register.
interface ssd_cfg_if #(
  parameter int DATA_BITS = ssd_pkg::SSD_TIME_BITS
);
  logic                             valid;
  logic                             ready;
  logic [ssd_pkg::CFG_IDX_BITS-1:0] index;
  logic [DATA_BITS-1:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/ssd_front.sv @@
// Front end: takes samples, picks the step, forms |step|*|P-T| and its sign.
// Depends on ssd_pkg; feeds ssd_queue.
module ssd_front #(
  parameter int TIME_BITS  = ssd_pkg::SSD_TIME_BITS,
  parameter int LEVEL_BITS = ssd_pkg::SSD_LEVEL_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [ssd_pkg::POWER_BITS-1:0]              power,
  input  logic [TIME_BITS-1:0]                        timestamp_ms,
  input  logic [ssd_pkg::POWER_BITS-1:0]              threshold,
  input  logic signed [LEVEL_BITS-1:0]                sound_step,
  input  logic signed [LEVEL_BITS-1:0]                silence_step,
  output logic                                        push_valid,
  input  logic                                        push_ready,
  output logic [LEVEL_BITS+ssd_pkg::POWER_BITS+TIME_BITS:0] push_data
);
  import ssd_pkg::*;

  localparam int MAG_BITS = LEVEL_BITS + POWER_BITS;

  logic                         valid_r, valid_nxt;
  logic                         neg_r, neg_nxt;
  logic [MAG_BITS-1:0]          mag_r, mag_nxt;
  logic [TIME_BITS-1:0]         now_r, now_nxt;

  logic                         accept;
  logic [POWER_BITS-1:0]        t_eff;
  logic                         at_or_above;
  logic [POWER_BITS-1:0]        diff;
  logic signed [LEVEL_BITS-1:0] step_sel;
  logic [LEVEL_BITS-1:0]        step_mag;

  assign in_ready = !valid_r || push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    t_eff       = (threshold == '0) ? POWER_BITS'(1) : threshold;
    at_or_above = (power >= t_eff);
    diff        = at_or_above ? (power - t_eff) : (t_eff - power);
    step_sel    = at_or_above ? sound_step : silence_step;
    // magnitude of the most negative step still fits unsigned
    step_mag    = step_sel[LEVEL_BITS-1] ? (~$unsigned(step_sel) + 1'b1)
                                         : $unsigned(step_sel);
  end

  always_comb begin
    valid_nxt = valid_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    now_nxt   = now_r;
    if (push_ready) begin
      valid_nxt = 1'b0;
    end
    if (accept) begin
      valid_nxt = 1'b1;
      neg_nxt   = step_sel[LEVEL_BITS-1];
      mag_nxt   = MAG_BITS'(step_mag) * MAG_BITS'(diff);
      now_nxt   = timestamp_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    now_r <= now_nxt;
  end

  assign push_valid = valid_r;
  assign push_data  = {neg_r, mag_r, now_r};

endmodule

@@ rtl/core/ssd_queue.sv @@
// Small register FIFO between the front and back ends.
// Depends on ssd_pkg for the default depth.
module ssd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ssd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import ssd_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                push, pop;

  assign push_ready = (count_r != CNT_BITS'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/ssd_back.sv @@
// Back end: divides by the threshold two bits a cycle, integrates, clamps,
// runs the mode machine and holds the result register. Depends on ssd_pkg.
module ssd_back #(
  parameter int TIME_BITS  = ssd_pkg::SSD_TIME_BITS,
  parameter int LEVEL_BITS = ssd_pkg::SSD_LEVEL_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        pop_valid,
  output logic                                        pop_ready,
  input  logic [LEVEL_BITS+ssd_pkg::POWER_BITS+TIME_BITS:0] pop_data,
  input  logic [ssd_pkg::POWER_BITS-1:0]              threshold,
  input  logic signed [LEVEL_BITS-1:0]                int_min,
  input  logic signed [LEVEL_BITS-1:0]                int_max,
  input  logic signed [LEVEL_BITS-1:0]                sound_on,
  input  logic signed [LEVEL_BITS-1:0]                silence_on,
  input  logic [TIME_BITS-1:0]                        lasting_ms,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [1:0]                                  sound_state,
  output logic                                        state_changed,
  output logic signed [LEVEL_BITS-1:0]                integrator_level
);
  import ssd_pkg::*;

  localparam int MAG_BITS = LEVEL_BITS + POWER_BITS;
  localparam int QW       = ((MAG_BITS + 1) / 2) * 2;
  localparam int ITERS    = QW / 2;
  localparam int CNT_BITS = $clog2(ITERS);
  localparam int SUM_BITS = QW + 2;
  localparam int REM_BITS = POWER_BITS + 1;

  typedef enum logic [3:0] {
    BK_IDLE   = 4'b0001,
    BK_DIV    = 4'b0010,
    BK_SUM    = 4'b0100,
    BK_DECIDE = 4'b1000
  } back_state_t;

  back_state_t                  state_r, state_nxt;
  logic [CNT_BITS-1:0]          cnt_r, cnt_nxt;
  logic [QW-1:0]                dvd_r, dvd_nxt;
  logic [REM_BITS-1:0]          rem_r, rem_nxt;
  logic                         neg_r, neg_nxt;
  logic [TIME_BITS-1:0]         now_r, now_nxt;
  logic signed [LEVEL_BITS-1:0] integ_r, integ_nxt;
  mode_t                        mode_r, mode_nxt;
  logic [TIME_BITS-1:0]         sil_start_r, sil_start_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_state_r, out_state_nxt;
  logic                         out_changed_r, out_changed_nxt;
  logic signed [LEVEL_BITS-1:0] out_level_r, out_level_nxt;

  logic [POWER_BITS-1:0]        t_eff;
  logic [REM_BITS:0]            s1, s2;
  logic [QW-1:0]                d1, d2;
  logic signed [SUM_BITS-1:0]   q_ext, delta, sum, lo_ext, hi_ext, c1, c2;
  logic [TIME_BITS-1:0]         elapsed;
  logic                         out_free;
  logic                         changed;

  // one restoring step: {new remainder, quotient bit}
  function automatic logic [REM_BITS:0] div_step(input logic [REM_BITS-1:0] rem,
                                                 input logic bit_in,
                                                 input logic [POWER_BITS-1:0] dvs);
    logic [REM_BITS-1:0] sh;
    sh = {rem[REM_BITS-2:0], bit_in};
    if (sh >= {1'b0, dvs}) begin
      div_step = {sh - {1'b0, dvs}, 1'b1};
    end else begin
      div_step = {sh, 1'b0};
    end
  endfunction

  always_comb begin
    t_eff  = (threshold == '0) ? POWER_BITS'(1) : threshold;
    s1     = div_step(rem_r, dvd_r[QW-1], t_eff);
    d1     = {dvd_r[QW-2:0], s1[0]};
    s2     = div_step(s1[REM_BITS:1], d1[QW-1], t_eff);
    d2     = {d1[QW-2:0], s2[0]};
    q_ext  = $signed(SUM_BITS'(dvd_r));
    delta  = neg_r ? -q_ext : q_ext;
    sum    = SUM_BITS'(integ_r) + delta;
    lo_ext = SUM_BITS'(int_min);
    hi_ext = SUM_BITS'(int_max);
    // lower clamp first, so crossed limits end at the upper one
    c1     = (sum < lo_ext) ? lo_ext : sum;
    c2     = (c1 > hi_ext) ? hi_ext : c1;
    elapsed = now_r - sil_start_r;
  end

  assign out_free  = !out_valid_r || out_ready;
  assign pop_ready = (state_r == BK_IDLE);

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    neg_nxt         = neg_r;
    now_nxt         = now_r;
    integ_nxt       = integ_r;
    mode_nxt        = mode_r;
    sil_start_nxt   = sil_start_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_state_nxt   = out_state_r;
    out_changed_nxt = out_changed_r;
    out_level_nxt   = out_level_r;
    changed         = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          neg_nxt   = pop_data[MAG_BITS+TIME_BITS];
          dvd_nxt   = QW'(pop_data[TIME_BITS +: MAG_BITS]);
          now_nxt   = pop_data[TIME_BITS-1:0];
          rem_nxt   = '0;
          cnt_nxt   = CNT_BITS'(ITERS - 1);
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        dvd_nxt = d2;
        rem_nxt = s2[REM_BITS:1];
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = BK_SUM;
        end
      end
      BK_SUM: begin
        integ_nxt = LEVEL_BITS'(c2);
        state_nxt = BK_DECIDE;
      end
      BK_DECIDE: begin
        if (out_free) begin
          unique case (mode_r)
            MODE_SILENCE: begin
              if (integ_r >= sound_on) begin
                mode_nxt = MODE_SOUND;
                changed  = 1'b1;
              end else if (elapsed >= lasting_ms) begin
                mode_nxt = MODE_LASTING;
                changed  = 1'b1;
              end
            end
            MODE_LASTING: begin
              if (integ_r >= sound_on) begin
                mode_nxt = MODE_SOUND;
                changed  = 1'b1;
              end
            end
            MODE_SOUND: begin
              if (integ_r <= silence_on) begin
                mode_nxt      = MODE_SILENCE;
                sil_start_nxt = now_r;
                changed       = 1'b1;
              end
            end
            default: begin
              mode_nxt = mode_r;
            end
          endcase
          out_valid_nxt   = 1'b1;
          out_state_nxt   = mode_code(mode_nxt);
          out_changed_nxt = changed;
          out_level_nxt   = integ_r;
          state_nxt       = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      integ_r     <= '0;
      mode_r      <= MODE_SILENCE;
      sil_start_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integ_r     <= integ_nxt;
      mode_r      <= mode_nxt;
      sil_start_r <= sil_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r         <= cnt_nxt;
    dvd_r         <= dvd_nxt;
    rem_r         <= rem_nxt;
    neg_r         <= neg_nxt;
    now_r         <= now_nxt;
    out_state_r   <= out_state_nxt;
    out_changed_r <= out_changed_nxt;
    out_level_r   <= out_level_nxt;
  end

  assign out_valid        = out_valid_r;
  assign sound_state      = out_state_r;
  assign state_changed    = out_changed_r;
  assign integrator_level = out_level_r;

endmodule

@@ rtl/core/sound_silence_detector.sv @@
// Top level of the sound/silence detector: register file plus front, queue, back.
// Depends on ssd_pkg, the three channel interfaces, ssd_front, ssd_queue, ssd_back.
//
//  channel | dir | beat contents                                  | handshake
//  in_ch   | in  | power (Q4.12), timestamp_ms                    | valid/ready
//  out_ch  | out | sound_state, state_changed, integrator_level   | valid/ready
//  cfg_ch  | in  | index (register number), data                  | valid/ready
//
// Flow: with Q = LEVEL_BITS+16 rounded up to even, the back end takes one beat at
//   a time, through the radix-4 threshold divider over Q quotient bits, then
//   integrate and decide. The front end takes a beat every cycle while the queue
//   has room, into a two-entry queue, so input and output stall independently.
// Reset: synchronous active low; registers return to their reset values, the
//   integrator to zero and the detector to silence.
// cfg_ch is always ready; write only while the block has nothing in flight.
module sound_silence_detector #(
  parameter int TIME_BITS  = ssd_pkg::SSD_TIME_BITS,
  parameter int LEVEL_BITS = ssd_pkg::SSD_LEVEL_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  ssd_in_if.sink   in_ch,
  ssd_out_if.source out_ch,
  ssd_cfg_if.sink  cfg_ch
);
  import ssd_pkg::*;

  localparam int ENTRY_BITS = 1 + LEVEL_BITS + POWER_BITS + TIME_BITS;

  // configuration registers
  logic [POWER_BITS-1:0]        threshold_r, threshold_nxt;
  logic signed [LEVEL_BITS-1:0] sound_step_r, sound_step_nxt;
  logic signed [LEVEL_BITS-1:0] silence_step_r, silence_step_nxt;
  logic signed [LEVEL_BITS-1:0] int_min_r, int_min_nxt;
  logic signed [LEVEL_BITS-1:0] int_max_r, int_max_nxt;
  logic signed [LEVEL_BITS-1:0] sound_on_r, sound_on_nxt;
  logic signed [LEVEL_BITS-1:0] silence_on_r, silence_on_nxt;
  logic [TIME_BITS-1:0]         lasting_ms_r, lasting_ms_nxt;

  // front -> queue -> back
  logic                  push_valid, push_ready;
  logic [ENTRY_BITS-1:0] push_data;
  logic                  pop_valid, pop_ready;
  logic [ENTRY_BITS-1:0] pop_data;

  assign cfg_ch.ready = 1'b1;

  // register writes: each register keeps only its own width of data
  always_comb begin
    threshold_nxt    = threshold_r;
    sound_step_nxt   = sound_step_r;
    silence_step_nxt = silence_step_r;
    int_min_nxt      = int_min_r;
    int_max_nxt      = int_max_r;
    sound_on_nxt     = sound_on_r;
    silence_on_nxt   = silence_on_r;
    lasting_ms_nxt   = lasting_ms_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_THRESHOLD:    threshold_nxt    = cfg_ch.data[POWER_BITS-1:0];
        REG_SOUND_STEP:   sound_step_nxt   = cfg_ch.data[LEVEL_BITS-1:0];
        REG_SILENCE_STEP: silence_step_nxt = cfg_ch.data[LEVEL_BITS-1:0];
        REG_INT_MIN:      int_min_nxt      = cfg_ch.data[LEVEL_BITS-1:0];
        REG_INT_MAX:      int_max_nxt      = cfg_ch.data[LEVEL_BITS-1:0];
        REG_SOUND_ON:     sound_on_nxt     = cfg_ch.data[LEVEL_BITS-1:0];
        REG_SILENCE_ON:   silence_on_nxt   = cfg_ch.data[LEVEL_BITS-1:0];
        REG_LASTING_MS:   lasting_ms_nxt   = cfg_ch.data[TIME_BITS-1:0];
        default:          threshold_nxt    = threshold_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= POWER_BITS'(DEF_THRESHOLD);
      sound_step_r   <= LEVEL_BITS'(DEF_SOUND_STEP);
      silence_step_r <= LEVEL_BITS'(DEF_SILENCE_STEP);
      int_min_r      <= LEVEL_BITS'(DEF_INT_MIN);
      int_max_r      <= LEVEL_BITS'(DEF_INT_MAX);
      sound_on_r     <= LEVEL_BITS'(DEF_SOUND_ON);
      silence_on_r   <= LEVEL_BITS'(DEF_SILENCE_ON);
      lasting_ms_r   <= TIME_BITS'(DEF_LASTING_MS);
    end else begin
      threshold_r    <= threshold_nxt;
      sound_step_r   <= sound_step_nxt;
      silence_step_r <= silence_step_nxt;
      int_min_r      <= int_min_nxt;
      int_max_r      <= int_max_nxt;
      sound_on_r     <= sound_on_nxt;
      silence_on_r   <= silence_on_nxt;
      lasting_ms_r   <= lasting_ms_nxt;
    end
  end

  // front: one beat per cycle while the queue has room, step select and |step|*|P-T| product
  ssd_front #(
    .TIME_BITS  (TIME_BITS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .power        (in_ch.power),
    .timestamp_ms (in_ch.timestamp_ms),
    .threshold    (threshold_r),
    .sound_step   (sound_step_r),
    .silence_step (silence_step_r),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  // decoupling queue
  ssd_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: divide, integrate, clamp, mode machine, result register
  ssd_back #(
    .TIME_BITS  (TIME_BITS),
    .LEVEL_BITS (LEVEL_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_data         (pop_data),
    .threshold        (threshold_r),
    .int_min          (int_min_r),
    .int_max          (int_max_r),
    .sound_on         (sound_on_r),
    .silence_on       (silence_on_r),
    .lasting_ms       (lasting_ms_r),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .sound_state      (out_ch.sound_state),
    .state_changed    (out_ch.state_changed),
    .integrator_level (out_ch.integrator_level)
  );

endmodule

@@ rtl/core/ssd_checker.sv @@
// Port-level checks of the sound/silence detector, bound to the top level.
// Depends on ssd_pkg, the channel interfaces and assert_macros.svh.
`include "assert_macros.svh"

module ssd_port_checker #(
  parameter int TIME_BITS  = ssd_pkg::SSD_TIME_BITS,
  parameter int LEVEL_BITS = ssd_pkg::SSD_LEVEL_BITS
) (
  input logic       clk,
  input logic       rst_n,
  ssd_out_if.source out_ch,
  ssd_cfg_if.sink   cfg_ch
);
  import ssd_pkg::*;

  // shadow of the registers the checks depend on, and of the last state shown
  logic signed [LEVEL_BITS-1:0] min_r, min_nxt;
  logic signed [LEVEL_BITS-1:0] max_r, max_nxt;
  logic signed [LEVEL_BITS-1:0] sound_on_r, sound_on_nxt;
  logic [1:0]                   last_state_r, last_state_nxt;
  logic                         cfg_wr, out_acc;

  assign cfg_wr  = cfg_ch.valid && cfg_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  always_comb begin
    min_nxt        = min_r;
    max_nxt        = max_r;
    sound_on_nxt   = sound_on_r;
    last_state_nxt = last_state_r;
    if (cfg_wr && cfg_reg_t'(cfg_ch.index) == REG_INT_MIN) begin
      min_nxt = cfg_ch.data[LEVEL_BITS-1:0];
    end
    if (cfg_wr && cfg_reg_t'(cfg_ch.index) == REG_INT_MAX) begin
      max_nxt = cfg_ch.data[LEVEL_BITS-1:0];
    end
    if (cfg_wr && cfg_reg_t'(cfg_ch.index) == REG_SOUND_ON) begin
      sound_on_nxt = cfg_ch.data[LEVEL_BITS-1:0];
    end
    if (out_acc) begin
      last_state_nxt = out_ch.sound_state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r        <= LEVEL_BITS'(DEF_INT_MIN);
      max_r        <= LEVEL_BITS'(DEF_INT_MAX);
      sound_on_r   <= LEVEL_BITS'(DEF_SOUND_ON);
      last_state_r <= STATE_SILENCE;
    end else begin
      min_r        <= min_nxt;
      max_r        <= max_nxt;
      sound_on_r   <= sound_on_nxt;
      last_state_r <= last_state_nxt;
    end
  end

  `SSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.sound_state) && $stable(out_ch.state_changed) && $stable(out_ch.integrator_level), "result changed while stalled")
  `SSD_ASSERT_IMP(a_change_flag, clk, rst_n, out_acc, out_ch.state_changed == (out_ch.sound_state != last_state_r), "change flag disagrees with state sequence")
  `SSD_ASSERT_IMP(a_level_clamped, clk, rst_n, out_ch.valid && (min_r <= max_r), (out_ch.integrator_level >= min_r) && (out_ch.integrator_level <= max_r), "integrator outside clamp")
  `SSD_ASSERT_IMP(a_sound_entry, clk, rst_n, out_ch.valid && out_ch.state_changed && (out_ch.sound_state == STATE_SOUND), out_ch.integrator_level >= sound_on_r, "sound declared below its level")
  `SSD_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_ch.valid, "result valid after reset")

endmodule

bind sound_silence_detector ssd_port_checker #(
  .TIME_BITS  (TIME_BITS),
  .LEVEL_BITS (LEVEL_BITS)
) u_ssd_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_ch (out_ch),
  .cfg_ch (cfg_ch)
);

@@ dv/ssd_checker.sv @@
// Scoreboard for the sound/silence detector: predicts each result beat and compares.
// Depends on ssd_pkg and the ssd_in_if, ssd_out_if and ssd_cfg_if interfaces.
module ssd_checker (
  input  logic clk,
  input  logic rst_n,
  ssd_in_if    in_ch,
  ssd_out_if   out_ch,
  ssd_cfg_if   cfg_ch,
  output int   mismatches,
  output int   pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssd_pkg::*;

  typedef struct packed {
    logic [1:0]          state;
    logic                changed;
    logic signed [15:0]  level;
  } detector_result_t;

  // register copies
  logic        [15:0] threshold;
  logic signed [15:0] step_loud, step_quiet, clamp_lo, clamp_hi;
  logic signed [15:0] level_sound, level_silence;
  logic        [31:0] lasting_ms;

  // detector state
  logic signed [15:0] integ;
  mode_t              det_mode;
  logic        [31:0] silence_t0;

  detector_result_t expected_results[$];

  function automatic detector_result_t advance_detector(input logic [15:0] pw,
                                                        input logic [31:0] now);
    longint           t, p, stp, diff, sum;
    logic [31:0]      since;
    detector_result_t r;
    t = longint'(threshold);
    if (t == 0) t = 1;
    p = longint'(pw);
    if (p >= t) begin
      stp  = longint'(step_loud);
      diff = p - t;
    end else begin
      stp  = longint'(step_quiet);
      diff = t - p;
    end
    // full-width product, division truncates toward zero
    sum = longint'(integ) + (stp * diff) / t;
    if (sum < longint'(clamp_lo)) sum = longint'(clamp_lo);
    if (sum > longint'(clamp_hi)) sum = longint'(clamp_hi);
    integ = sum[15:0];

    since     = now - silence_t0;
    r.changed = 1'b0;
    if ((det_mode == MODE_SILENCE || det_mode == MODE_LASTING) && integ >= level_sound) begin
      det_mode  = MODE_SOUND;
      r.changed = 1'b1;
    end else if (det_mode == MODE_SOUND && integ <= level_silence) begin
      det_mode   = MODE_SILENCE;
      silence_t0 = now;
      r.changed  = 1'b1;
    end else if (det_mode == MODE_SILENCE && since >= lasting_ms) begin
      det_mode  = MODE_LASTING;
      r.changed = 1'b1;
    end

    case (det_mode)
      MODE_SOUND:   r.state = STATE_SOUND;
      MODE_LASTING: r.state = STATE_LASTING;
      default:      r.state = STATE_SILENCE;
    endcase
    r.level = integ;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    int               bad;
    detector_result_t want;
    bad = 0;
    if (!rst_n) begin
      threshold     = 16'(DEF_THRESHOLD);
      step_loud     = 16'(DEF_SOUND_STEP);
      step_quiet    = 16'(DEF_SILENCE_STEP);
      clamp_lo      = 16'(DEF_INT_MIN);
      clamp_hi      = 16'(DEF_INT_MAX);
      level_sound   = 16'(DEF_SOUND_ON);
      level_silence = 16'(DEF_SILENCE_ON);
      lasting_ms    = 32'(DEF_LASTING_MS);
      integ         = '0;
      det_mode      = MODE_SILENCE;
      silence_t0    = '0;
      expected_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got state %0d changed %0d level %0d",
                   $time, out_ch.sound_state, out_ch.state_changed, out_ch.integrator_level);
          bad = 1;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.sound_state !== want.state) begin
            $display("%0t: sound_state expected %0d, got %0d",
                     $time, want.state, out_ch.sound_state);
            bad = 1;
          end
          if (out_ch.state_changed !== want.changed) begin
            $display("%0t: state_changed expected %0d, got %0d",
                     $time, want.changed, out_ch.state_changed);
            bad = 1;
          end
          if (out_ch.integrator_level !== want.level) begin
            $display("%0t: integrator_level expected %0d, got %0d",
                     $time, want.level, out_ch.integrator_level);
            bad = 1;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_THRESHOLD:    threshold     = cfg_ch.data[15:0];
          REG_SOUND_STEP:   step_loud     = cfg_ch.data[15:0];
          REG_SILENCE_STEP: step_quiet    = cfg_ch.data[15:0];
          REG_INT_MIN:      clamp_lo      = cfg_ch.data[15:0];
          REG_INT_MAX:      clamp_hi      = cfg_ch.data[15:0];
          REG_SOUND_ON:     level_sound   = cfg_ch.data[15:0];
          REG_SILENCE_ON:   level_silence = cfg_ch.data[15:0];
          REG_LASTING_MS:   lasting_ms    = cfg_ch.data[31:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(advance_detector(in_ch.power, in_ch.timestamp_ms));
    end
    mismatches      <= mismatches + bad;
    pending_results <= expected_results.size();
  end

endmodule

@@ dv/tb_sound_silence_detector.sv @@
// Top of the sound/silence detector testbench: clock, reset, stimulus and verdict.
// Depends on ssd_pkg, the three channel interfaces, the block and ssd_checker.
module tb_sound_silence_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import ssd_pkg::*;

  localparam int LONG_STALL  = 300;     // receiver hold-off, in cycles
  localparam int DRAIN_TAIL  = 40;      // settling margin after the last result
  localparam int CYCLE_LIMIT = 400_000; // several times the slowest legal run

  logic clk;
  logic rst_n;

  ssd_in_if  in_ch ();
  ssd_out_if out_ch ();
  ssd_cfg_if cfg_ch ();

  int mismatches;
  int pending_results;

  // idle rates in percent, per side
  int send_idle_pct;
  int recv_idle_pct;

  // long receiver hold-off: stimulus asks, receiver serves
  int stall_asks;
  int stall_served = 0;

  int          cycle_count = 0;
  int          samples_sent;
  int          reg_writes;
  logic [15:0] cur_thr;   // threshold as last programmed, steers loud/quiet picks
  logic [31:0] ts_now;

  sound_silence_detector DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ssd_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when one is asked for.
  // Only one assignment to ready per clock edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_asks != stall_served) begin
        stall_served  <= stall_served + 1;
        out_ch.ready  <= 1'b0;
        repeat (LONG_STALL - 1) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // One sample beat. Valid stays high on return, so back-to-back beats never
  // drop it; an idle gap lowers it first.
  task automatic send_sample(input logic [POWER_BITS-1:0] pw, input logic [31:0] ts);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.power        <= pw;
    in_ch.timestamp_ms <= ts;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  // Stop offering and wait until every predicted result has come back.
  // The first edge lets the checker count the last accepted beat.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    reg_writes++;
  endtask

  // Full register load, only with nothing in flight.
  task automatic program_regs(input int thr, input int loud_step, input int quiet_step,
                              input int lo, input int hi, input int on_lvl,
                              input int off_lvl, input logic [31:0] last_ms);
    drain_results();
    write_reg(REG_THRESHOLD,    32'(thr));
    write_reg(REG_SOUND_STEP,   32'(loud_step));
    write_reg(REG_SILENCE_STEP, 32'(quiet_step));
    write_reg(REG_INT_MIN,      32'(lo));
    write_reg(REG_INT_MAX,      32'(hi));
    write_reg(REG_SOUND_ON,     32'(on_lvl));
    write_reg(REG_SILENCE_ON,   32'(off_lvl));
    write_reg(REG_LASTING_MS,   last_ms);
    cfg_ch.valid <= 1'b0;
    cur_thr = thr[15:0];
  endtask

  // Mostly sane settings so the detector cycles through all three states:
  // positive loud step, negative quiet step, levels inside the clamps.
  // Now and then a wild threshold, step or lasting time.
  task automatic randomize_regs();
    int          thr, loud_step, quiet_step, lo, hi, span, on_lvl, off_lvl;
    logic [31:0] last_ms;
    thr        = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
                                             : int'($urandom_range(1, 8192));
    loud_step  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                             : int'($urandom_range(1, 3000));
    quiet_step = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                             : -int'($urandom_range(1, 3000));
    lo         = -int'($urandom_range(0, 2000));
    hi         = lo + int'($urandom_range(200, 4000));
    span       = hi - lo;
    off_lvl    = lo + int'($urandom_range(0, span / 3));
    on_lvl     = hi - int'($urandom_range(0, span / 3));
    last_ms    = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1500);
    program_regs(thr, loud_step, quiet_step, lo, hi, on_lvl, off_lvl, last_ms);
  endtask

  // Bursts of loud or quiet samples with slowly advancing time; one sample in
  // twenty is noise: any power and a jump to any timestamp (wraps included).
  task automatic random_samples(input int count);
    int                    burst_left;
    bit                    loud;
    logic [15:0]           thr_eff;
    logic [POWER_BITS-1:0] pw;
    burst_left = 0;
    loud       = 1'b0;
    thr_eff    = (cur_thr == 0) ? 16'd1 : cur_thr;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        loud       = 1'($urandom_range(0, 1));
        burst_left = $urandom_range(1, 60);
      end
      burst_left--;
      if ($urandom_range(0, 19) == 0) begin
        pw     = POWER_BITS'($urandom_range(0, 65535));
        ts_now = $urandom();
      end else begin
        pw     = loud ? POWER_BITS'($urandom_range(thr_eff, 65535))
                      : POWER_BITS'($urandom_range(0, thr_eff - 1));
        ts_now = ts_now + $urandom_range(0, 60);
      end
      send_sample(pw, ts_now);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.power        = '0;
    in_ch.timestamp_ms = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_THRESHOLD;
    cfg_ch.data        = '0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    stall_asks         = 0;
    samples_sent       = 0;
    reg_writes         = 0;
    cur_thr            = 16'(DEF_THRESHOLD);
    ts_now             = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed, reset settings (T=410, steps +/-100, clamp 0..1000) ---
    send_sample(16'h0000, 32'd0);    // silent floor, clamps at min
    send_sample(16'd410,  32'd10);   // power equals threshold: zero delta
    send_sample(16'd409,  32'd20);   // tiny deficit truncates to zero
    send_sample(16'hFFFF, 32'd30);   // full scale: clamps at max, enters sound
    // walk down to the silence level just before the timestamp wraps
    for (int i = 0; i < 8; i++)
      send_sample(16'h0000, 32'hFFFF_FF00 + 32'(i));
    send_sample(16'd410,  32'h0001_0000);  // elapsed across the wrap, still short
    send_sample(16'd410,  32'h0002_0000);  // elapsed over 120 s: lasting silence
    send_sample(16'hFFFF, 32'h0002_0001);  // lasting silence back to sound

    // --- zero threshold, extreme steps and levels, lasting time zero ---
    program_regs(0, 32767, -32768, -32768, 32767, 32767, -32768, 32'd0);
    send_sample(16'hFFFF, 32'd100);  // huge delta at full width, top clamp, sound
    send_sample(16'h0000, 32'd200);
    send_sample(16'h0000, 32'd300);  // bottom clamp, sound to silence
    send_sample(16'h0000, 32'd300);  // zero elapsed already meets lasting time
    send_sample(16'h0001, 32'd400);  // power equals the forced threshold of one

    // --- crossed clamps: upper clamp wins; max threshold, max lasting time ---
    program_regs(65535, -32768, 32767, 500, -500, 0, -1, 32'hFFFF_FFFF);
    send_sample(16'hFFFF, 32'd0);
    send_sample(16'h0000, 32'hFFFF_FFFF);

    // --- random part: three idle profiles, three settings each ---
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 34; recv_idle_pct = 74; end
        1: begin send_idle_pct = 74; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      ts_now = $urandom();
      for (int seg = 0; seg < 3; seg++) begin
        randomize_regs();
        // receiver goes dark while samples keep coming: queue fills, input stalls
        if (phase == 2 && seg == 1)
          stall_asks <= stall_asks + 1;
        random_samples(90);
      end
    end

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("run: %0d samples checked over %0d register settings,", samples_sent,
             reg_writes / 8 + 1);
    $display("     with both sides throttled, one long output hold-off and a full-speed pass");
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
